// ===== src/rgb_box_smooth_3x3_core_defines.svh =====
// ----------------------------------------------------------------------------
// rgb box smooth assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_SMOOTH_3X3_CORE_DEFINES_SVH
`define RGB_BOX_SMOOTH_3X3_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define RBS3_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define RBS3_ASSERT(lbl, prop, msg) `RBS3_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/rbs3_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth package
// sizes, pipeline payload types and divider constants of the 3x3 mean filter
// ----------------------------------------------------------------------------
package rbs3_pkg;

  localparam int unsigned MAX_SIZE   = 512;
  localparam int unsigned MIN_SIZE   = 2;
  localparam int unsigned SIZE_RESET = 512;

  localparam int unsigned CH_W   = 16;
  localparam int unsigned CH_N   = 3;
  localparam int unsigned PIX_W  = CH_N * CH_W;
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned SIZE_W = $clog2(MAX_SIZE + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_SIZE + 2);
  localparam int unsigned COL_W  = $clog2(MAX_SIZE);

  // three rows, then three columns of 16-bit samples
  localparam int unsigned VSUM_W = CH_W + 2;
  localparam int unsigned HSUM_W = CH_W + 4;

  // exact reciprocals: /3 for 19-bit operands, /9 for 20-bit operands
  localparam int unsigned RECIP_W = 21;
  localparam int unsigned PROD_W  = HSUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3 = 21'd699051;
  localparam logic [RECIP_W-1:0] RECIP9 = 21'd1864136;
  localparam int unsigned SHIFT3 = 21;
  localparam int unsigned SHIFT9 = 24;

  typedef logic [CH_N-1:0][CH_W-1:0] pix_t;

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_e;

  // per-item window control, decided from the raster position
  typedef struct packed {
    logic emit;
    logic last;
    logic left_ok;
    logic right_ok;
  } ctl_t;

  // vertical column sum and number of rows inside the image
  typedef struct packed {
    logic [CH_N-1:0][VSUM_W-1:0] sum;
    logic [1:0]                  rows;
  } col_t;

  // window sum ready for division
  typedef struct packed {
    logic [CH_N-1:0][HSUM_W-1:0] sum;
    div_e                        div;
    logic                        last;
  } wsum_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [CFG_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (int'(s) < int'(MIN_SIZE)) begin
      r = SIZE_W'(MIN_SIZE);
    end else if (int'(s) > int'(MAX_SIZE)) begin
      r = SIZE_W'(MAX_SIZE);
    end else begin
      r = SIZE_W'(s);
    end
    return r;
  endfunction

endpackage

// ===== src/rbs3_in_if.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth input channel
// valid/ready request channel carrying one pixel or drain item
// ----------------------------------------------------------------------------
interface rbs3_in_if;
  import rbs3_pkg::*;

  logic            valid;
  logic            ready;
  logic            command;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, command, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

// ===== src/rbs3_out_if.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth output channel
// valid/ready request channel carrying one filtered pixel
// ----------------------------------------------------------------------------
interface rbs3_out_if;
  import rbs3_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            last_pixel;

  modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

// ===== src/rgb_box_smooth_3x3_core.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth 3x3 core
// path: a result passes the B, C, D and E stage registers, then the output register
// throughput: one request per cycle while the output register can take data
// reset: position counters clear, image size returns to 512, the line ram is not cleared
// ----------------------------------------------------------------------------
module rgb_box_smooth_3x3_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbs3_pkg::CFG_W-1:0] cfg_wdata_i,
  rbs3_in_if.sink                    pix_req_i,
  rbs3_out_if.source                 pix_res_o
);
  import rbs3_pkg::*;

  // pipeline:
  //   accept : position decode, line ram read at the column address
  //   B      : ram data back, column sum over rows y-2..y, write back {y, y-1}
  //   C      : three-column window, horizontal sum with clipping
  //   D      : reciprocal multiply
  //   E/out  : shift select, output register
  // every stage moves together whenever the output register can take data

  // global advance and input handshake
  logic adv;
  logic accept;

  // configuration and raster position
  logic [CFG_W-1:0]  size_q;
  logic [SIZE_W-1:0] n_q;
  logic [SIZE_W-1:0] n_cur;
  logic [ROW_W-1:0]  y_q;
  logic [ROW_W-1:0]  y_d;
  logic [COL_W-1:0]  x_q;
  logic [COL_W-1:0]  x_d;
  logic              first;
  logic              row_end;
  logic              at_last;
  ctl_t              ctl_a;
  logic [2:0]        vmask_a;
  pix_t              in_pix;

  // stage B
  logic             b_valid_q;
  ctl_t             b_ctl_q;
  logic [2:0]       b_vmask_q;
  pix_t             b_pix_q;
  logic [COL_W-1:0] b_x_q;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] ram_wdata;
  pix_t             p_up;
  pix_t             p_dn;
  col_t             b_col;

  // later stages
  logic  d_valid;
  wsum_t d_wsum;
  logic  e_valid;
  pix_t  e_mean;
  logic  e_last;

  // output register
  logic out_valid_q;
  pix_t out_pix_q;
  logic out_last_q;

  assign adv    = !out_valid_q || pix_res_o.ready;
  assign accept = adv && pix_req_i.valid;
  assign pix_req_i.ready = adv;

  // red in lane 0, blue in lane 2
  assign in_pix = {pix_req_i.in_blue, pix_req_i.in_green, pix_req_i.in_red};

  // image size register, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CFG_W'(SIZE_RESET);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // position decode: item role comes from its place in the stream, command is not needed
  // row y, column x of the request; result is for (y-1, x-1), or (y-2, n-1) at x == 0
  always_comb begin
    first   = (y_q == '0) && (x_q == '0);
    n_cur   = first ? clamp_size(size_q) : n_q;
    row_end = (SIZE_W'(x_q) + SIZE_W'(1)) == n_cur;
    at_last = (x_q == '0) && (y_q == (ROW_W'(n_cur) + ROW_W'(1)));

    // first result once the row below the first center row is complete up to column 1
    ctl_a.emit     = (y_q >= ROW_W'(2)) || ((y_q == ROW_W'(1)) && (x_q != '0));
    ctl_a.last     = at_last;
    // left column missing for center column 0, right column missing at the row wrap
    ctl_a.left_ok  = (x_q != COL_W'(1));
    ctl_a.right_ok = (x_q != '0);

    // rows y-2, y-1 and y that fall inside the image
    vmask_a[2] = (y_q >= ROW_W'(2));
    vmask_a[1] = (y_q != '0) && (y_q <= ROW_W'(n_cur));
    vmask_a[0] = (y_q < ROW_W'(n_cur));

    priority if (at_last) begin
      x_d = '0;
      y_d = '0;
    end else if (row_end) begin
      x_d = '0;
      y_d = y_q + ROW_W'(1);
    end else begin
      x_d = x_q + COL_W'(1);
      y_d = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q <= '0;
      x_q <= '0;
      n_q <= SIZE_W'(MAX_SIZE);
    end else if (accept) begin
      y_q <= y_d;
      x_q <= x_d;
      n_q <= n_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= pix_req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_ctl_q   <= ctl_a;
      b_vmask_q <= vmask_a;
      b_pix_q   <= in_pix;
      b_x_q     <= x_q;
    end
  end

  // line ram word per column: upper half row y-1, lower half row y-2
  // a column is read again only n >= 2 requests later, after its write back,
  // so no forwarding path is needed
  rbs3_line_ram #(
    .DEPTH (MAX_SIZE),
    .WIDTH (2 * PIX_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv && b_valid_q),
    .waddr_i (b_x_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (x_q),
    .rdata_o (ram_rdata)
  );

  // column sum with rows outside the image masked out
  always_comb begin
    p_up = ram_rdata[2*PIX_W-1:PIX_W];
    p_dn = ram_rdata[PIX_W-1:0];
    for (int ch = 0; ch < CH_N; ch++) begin
      b_col.sum[ch] = (b_vmask_q[2] ? VSUM_W'(p_dn[ch]) : '0)
                    + (b_vmask_q[1] ? VSUM_W'(p_up[ch]) : '0)
                    + (b_vmask_q[0] ? VSUM_W'(b_pix_q[ch]) : '0);
    end
    b_col.rows = 2'(b_vmask_q[2]) + 2'(b_vmask_q[1]) + 2'(b_vmask_q[0]);
  end

  // shift the column up one row on write back
  assign ram_wdata = {b_pix_q, p_up};

  rbs3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .col_valid_i (b_valid_q),
    .ctl_i       (b_ctl_q),
    .col_i       (b_col),
    .sum_valid_o (d_valid),
    .wsum_o      (d_wsum)
  );

  rbs3_mean_div u_mean_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .sum_valid_i  (d_valid),
    .wsum_i       (d_wsum),
    .mean_valid_o (e_valid),
    .mean_o       (e_mean),
    .last_o       (e_last)
  );

  // output register, holds while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= e_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q  <= e_mean;
      out_last_q <= e_last;
    end
  end

  assign pix_res_o.valid      = out_valid_q;
  assign pix_res_o.out_red    = out_pix_q[0];
  assign pix_res_o.out_green  = out_pix_q[1];
  assign pix_res_o.out_blue   = out_pix_q[2];
  assign pix_res_o.last_pixel = out_last_q;

endmodule

// ===== src/rbs3_line_ram.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth line ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rbs3_line_ram #(
  parameter  int unsigned DEPTH = 512,
  parameter  int unsigned WIDTH = 96,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rbs3_window.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth window
// three-column shift window and horizontal sum with clipping
// ----------------------------------------------------------------------------
module rbs3_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            col_valid_i,
  input  rbs3_pkg::ctl_t  ctl_i,
  input  rbs3_pkg::col_t  col_i,
  output logic            sum_valid_o,
  output rbs3_pkg::wsum_t wsum_o
);
  import rbs3_pkg::*;

  logic  c_valid_q;
  ctl_t  c_ctl_q;
  col_t  cur_q;
  col_t  w1_q;
  col_t  w2_q;
  logic  d_valid_q;
  wsum_t d_wsum_q;
  wsum_t d_wsum_d;
  logic [1:0] hcnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv_i) begin
      c_valid_q <= col_valid_i;
      d_valid_q <= c_valid_q && c_ctl_q.emit;
    end
  end

  // window shifts only when a new column arrives
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (col_valid_i) begin
        c_ctl_q <= ctl_i;
        cur_q   <= col_i;
        w1_q    <= cur_q;
        w2_q    <= w1_q;
      end
      d_wsum_q <= d_wsum_d;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      d_wsum_d.sum[ch] = (c_ctl_q.left_ok ? HSUM_W'(w2_q.sum[ch]) : '0)
                       + HSUM_W'(w1_q.sum[ch])
                       + (c_ctl_q.right_ok ? HSUM_W'(cur_q.sum[ch]) : '0);
    end
    hcnt = 2'd1 + 2'(c_ctl_q.left_ok) + 2'(c_ctl_q.right_ok);
    priority if ((w1_q.rows == 2'd3) && (hcnt == 2'd3)) begin
      d_wsum_d.div = DIV9;
    end else if ((w1_q.rows == 2'd2) && (hcnt == 2'd2)) begin
      d_wsum_d.div = DIV4;
    end else begin
      d_wsum_d.div = DIV6;
    end
    d_wsum_d.last = c_ctl_q.last;
  end

  assign sum_valid_o = d_valid_q;
  assign wsum_o      = d_wsum_q;

endmodule

// ===== src/rbs3_mean_div.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth mean divider
// divide window sums by 4 with a shift, by 6 or 9 with reciprocal multiply
// ----------------------------------------------------------------------------
module rbs3_mean_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            sum_valid_i,
  input  rbs3_pkg::wsum_t wsum_i,
  output logic            mean_valid_o,
  output rbs3_pkg::pix_t  mean_o,
  output logic            last_o
);
  import rbs3_pkg::*;

  logic                        e_valid_q;
  logic [CH_N-1:0][PROD_W-1:0] prod_q;
  logic [CH_N-1:0][PROD_W-1:0] prod_d;
  logic [CH_N-1:0][HSUM_W-1:0] op;
  logic [RECIP_W-1:0]          recip;
  pix_t                        quart_q;
  pix_t                        quart_d;
  div_e                        div_q;
  logic                        last_q;

  // divide by 6 as halve then divide by 3
  always_comb begin
    recip = (wsum_i.div == DIV6) ? RECIP3 : RECIP9;
    for (int ch = 0; ch < CH_N; ch++) begin
      op[ch]      = (wsum_i.div == DIV6) ? (wsum_i.sum[ch] >> 1) : wsum_i.sum[ch];
      prod_d[ch]  = PROD_W'(op[ch]) * PROD_W'(recip);
      quart_d[ch] = wsum_i.sum[ch][CH_W+1:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv_i) begin
      e_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q  <= prod_d;
      quart_q <= quart_d;
      div_q   <= wsum_i.div;
      last_q  <= wsum_i.last;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      unique case (div_q)
        DIV4:    mean_o[ch] = quart_q[ch];
        DIV6:    mean_o[ch] = prod_q[ch][SHIFT3 +: CH_W];
        DIV9:    mean_o[ch] = prod_q[ch][SHIFT9 +: CH_W];
        default: mean_o[ch] = quart_q[ch];
      endcase
    end
  end

  assign mean_valid_o = e_valid_q;
  assign last_o       = last_q;

endmodule

// ===== src/rbs3_checker.sv =====
// ----------------------------------------------------------------------------
// rgb box smooth checker
// port-level assertions bound to the core
// ----------------------------------------------------------------------------
`include "rgb_box_smooth_3x3_core_defines.svh"

module rbs3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_red_i,
  input logic [15:0] out_green_i,
  input logic [15:0] out_blue_i,
  input logic        out_last_i
);

  // a stalled result stays offered
  `RBS3_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")

  // a stalled result keeps its payload
  `RBS3_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_red_i) && $stable(out_green_i) && $stable(out_blue_i) && $stable(out_last_i), "stalled result changed")

  // the pipeline takes requests exactly when the output register can move
  `RBS3_ASSERT(a_ready_rule, in_ready_i == (!out_valid_i || out_ready_i), "ready mismatch")

  // a new result appears only if the pipeline advanced in the previous cycle
  `RBS3_ASSERT(a_rise_adv, $rose(out_valid_i) |-> $past(in_ready_i), "result without advance")

endmodule

bind rgb_box_smooth_3x3_core rbs3_checker u_rbs3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_req_i.ready),
  .out_valid_i (pix_res_o.valid),
  .out_ready_i (pix_res_o.ready),
  .out_red_i   (pix_res_o.out_red),
  .out_green_i (pix_res_o.out_green),
  .out_blue_i  (pix_res_o.out_blue),
  .out_last_i  (pix_res_o.last_pixel)
);

// ===== tb/sv/rgb_box_smooth_3x3_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb box smooth 3x3 core testbench
// streams square rgb images with their drain requests through the core under
// several handshake gap patterns, predicts every clipped 3x3 truncated mean
// and checks each filtered pixel in order
// ----------------------------------------------------------------------------
module rgb_box_smooth_3x3_core_tb;
  import rbs3_pkg::*;

  // ring of two full-size rows plus four pixels, deeper than the line ram
  localparam int unsigned RING_DEPTH = 2 * MAX_SIZE + 4;
  // a result passes the core's B to E stage registers and its output register
  localparam int unsigned LATENCY    = 4;
  localparam int unsigned SETTLE     = LATENCY + 8;
  localparam int unsigned WATCHDOG   = 4000;
  localparam int unsigned PHASE_REQS = 400;
  // long receiver hold-off while the sender keeps offering
  localparam int unsigned HOLD_AT    = 300;
  localparam int unsigned HOLD_LEN   = 600;
  localparam int unsigned MAX_REPORT = 10;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SEND,
    GAP_RECV,
    GAP_BOTH
  } gap_mode_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // one request: pixel or drain, decided by its position in the image
  typedef struct packed {
    logic cmd;
    rgb_t pix;
  } pix_req_t;

  // one filtered pixel
  typedef struct packed {
    rgb_t pix;
    logic last;
  } mean_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  rbs3_in_if  req_if ();
  rbs3_out_if res_if ();

  rgb_box_smooth_3x3_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_req_i   (req_if),
    .pix_res_o   (res_if)
  );

  // pending requests, filled by the stimulus, drained by the driver
  pix_req_t pixel_q[$];
  // predicted filtered pixels, oldest first
  mean_t    mean_q[$];

  gap_mode_e gap_mode;

  // predictor state: register copy, latched size, position counters, ring
  logic [CFG_W-1:0] size_cfg;
  int unsigned      frame_size;
  int unsigned      frame_pos;
  int unsigned      row_pos;
  int unsigned      col_pos;
  rgb_t             line_ring [RING_DEPTH];

  int unsigned req_count;
  int unsigned mean_count;
  int unsigned last_count;
  int unsigned frame_count;
  int unsigned min_size;
  int unsigned max_size;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  int unsigned hold_left;
  logic        hold_on;
  logic        hold_done;

  pix_req_t nxt_req;
  pix_req_t took_req;
  mean_t    got_mean;
  mean_t    want_mean;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // predictor: clipped 3x3 mean, results trail the input by size+1 requests
  // ------------------------------------------------------------------------
  function automatic void smooth_step(input pix_req_t rq);
    int unsigned n, t, rlo, rhi, clo, chi, cnt, slot;
    logic [HSUM_W-1:0] sum_r, sum_g, sum_b;
    mean_t m;
    // size is latched on the first request of an image, out of range clamps
    if (frame_pos == 0) begin
      if (size_cfg < MIN_SIZE) begin
        frame_size = MIN_SIZE;
      end else if (size_cfg > MAX_SIZE) begin
        frame_size = MAX_SIZE;
      end else begin
        frame_size = size_cfg;
      end
    end
    n = frame_size;
    t = frame_pos;
    // the first n*n requests are pixels whatever their command bit says
    if (t < n * n) begin
      line_ring[t % RING_DEPTH] = rq.pix;
    end
    if (t < n + 1) begin
      frame_pos = t + 1;
      return;
    end
    rlo = (row_pos == 0) ? 0 : row_pos - 1;
    rhi = (row_pos + 1 >= n) ? n - 1 : row_pos + 1;
    clo = (col_pos == 0) ? 0 : col_pos - 1;
    chi = (col_pos + 1 >= n) ? n - 1 : col_pos + 1;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int unsigned rr = rlo; rr <= rhi; rr++) begin
      for (int unsigned cc = clo; cc <= chi; cc++) begin
        slot  = (rr * n + cc) % RING_DEPTH;
        sum_r = sum_r + line_ring[slot].red;
        sum_g = sum_g + line_ring[slot].green;
        sum_b = sum_b + line_ring[slot].blue;
      end
    end
    // 4 at corners, 6 on edges, 9 inside
    cnt = (rhi - rlo + 1) * (chi - clo + 1);
    m.pix.red   = CH_W'(sum_r / cnt);
    m.pix.green = CH_W'(sum_g / cnt);
    m.pix.blue  = CH_W'(sum_b / cnt);
    m.last      = (row_pos == n - 1) && (col_pos == n - 1);
    mean_q.push_back(m);
    if (m.last) begin
      frame_pos = 0;
      row_pos   = 0;
      col_pos   = 0;
    end else begin
      frame_pos = t + 1;
      if (col_pos + 1 >= n) begin
        col_pos = 0;
        row_pos = row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    end
  endfunction

  function automatic bit send_gap();
    return (gap_mode == GAP_SEND && $urandom_range(99) < 60) ||
           (gap_mode == GAP_BOTH && $urandom_range(99) < 6);
  endfunction

  function automatic bit recv_gap();
    return (gap_mode == GAP_RECV && $urandom_range(99) < 60) ||
           (gap_mode == GAP_BOTH && $urandom_range(99) < 6);
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    logic [CH_W-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      default: v = CH_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic fail_note(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORT) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  // ------------------------------------------------------------------------
  // driver: offers queued requests, runs the predictor on each accepted one
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.command  <= 1'b0;
      req_if.in_red   <= '0;
      req_if.in_green <= '0;
      req_if.in_blue  <= '0;
      req_count       <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        took_req.cmd       = req_if.command;
        took_req.pix.red   = req_if.in_red;
        took_req.pix.green = req_if.in_green;
        took_req.pix.blue  = req_if.in_blue;
        smooth_step(took_req);
        req_count <= req_count + 1;
      end
      // a held request stays up untouched until it is taken
      if (!req_if.valid || req_if.ready) begin
        if (pixel_q.size() != 0 && !send_gap()) begin
          nxt_req = pixel_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.command  <= nxt_req.cmd;
          req_if.in_red   <= nxt_req.pix.red;
          req_if.in_green <= nxt_req.pix.green;
          req_if.in_blue  <= nxt_req.pix.blue;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // long hold-off of the result side, counted here on its own
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_on   <= 1'b0;
      hold_done <= 1'b0;
    end else if (!hold_done && req_count >= HOLD_AT && pixel_q.size() != 0) begin
      hold_left <= HOLD_LEN;
      hold_on   <= 1'b1;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_on   <= (hold_left > 1);
    end
  end

  // ------------------------------------------------------------------------
  // monitor: takes results, compares with the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      mean_count   <= 0;
      last_count   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_mean.pix.red   = res_if.out_red;
        got_mean.pix.green = res_if.out_green;
        got_mean.pix.blue  = res_if.out_blue;
        got_mean.last      = res_if.last_pixel;
        mean_count <= mean_count + 1;
        if (got_mean.last === 1'b1) begin
          last_count <= last_count + 1;
        end
        if (mean_q.size() == 0) begin
          fail_note($sformatf("unexpected result rgb=%h/%h/%h last=%b",
                              got_mean.pix.red, got_mean.pix.green,
                              got_mean.pix.blue, got_mean.last));
        end else begin
          want_mean = mean_q.pop_front();
          if (got_mean !== want_mean) begin
            fail_note($sformatf(
              "result %0d: exp rgb=%h/%h/%h last=%b, got rgb=%h/%h/%h last=%b",
              mean_count, want_mean.pix.red, want_mean.pix.green,
              want_mean.pix.blue, want_mean.last, got_mean.pix.red,
              got_mean.pix.green, got_mean.pix.blue, got_mean.last));
          end
        end
      end
      res_if.ready <= !hold_on && !recv_gap();
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG) begin
          $display("[%0t] timeout: no traffic for %0d cycles, %0d results pending",
                   $time, WATCHDOG, mean_q.size());
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  task automatic push_req(input logic cmd, input logic [CH_W-1:0] r,
                          input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    pix_req_t rq;
    rq.cmd       = cmd;
    rq.pix.red   = r;
    rq.pix.green = g;
    rq.pix.blue  = b;
    pixel_q.push_back(rq);
  endtask

  // wait until every request is taken and every result has come back,
  // sampled away from the active edge so that queue and handshake updates
  // of that edge have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || req_if.valid || mean_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    size_cfg     = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v);
    return (v < MIN_SIZE) ? MIN_SIZE : ((v > MAX_SIZE) ? MAX_SIZE : v);
  endfunction

  // random image of the current size plus its drains, a few with a
  // command bit that disagrees with the position
  task automatic queue_image(output int unsigned n_reqs);
    int unsigned n;
    n = eff_size(size_cfg);
    for (int unsigned p = 0; p < n * n; p++) begin
      push_req($urandom_range(15) == 0, rand_chan(), rand_chan(), rand_chan());
    end
    for (int unsigned d = 0; d <= n; d++) begin
      push_req($urandom_range(15) != 0, rand_chan(), rand_chan(), rand_chan());
    end
    n_reqs = n * n + n + 1;
    frame_count++;
    if (n < min_size) min_size = n;
    if (n > max_size) max_size = n;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    logic [CFG_W-1:0] v;
    case ($urandom_range(19))
      0: v = CFG_W'($urandom_range(1));       // below range, acts as 2
      1: v = CFG_W'(MIN_SIZE);
      2, 3, 4: v = CFG_W'($urandom_range(20, 9));
      default: v = CFG_W'($urandom_range(8, 3));
    endcase
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    int unsigned n_reqs;
    int unsigned phase_reqs;
    gap_mode_e   modes [4];

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req_if.valid    = 1'b0;
    req_if.command  = 1'b0;
    req_if.in_red   = '0;
    req_if.in_green = '0;
    req_if.in_blue  = '0;
    res_if.ready    = 1'b0;
    gap_mode        = GAP_NONE;
    size_cfg        = CFG_W'(SIZE_RESET);
    frame_size      = MAX_SIZE;
    frame_pos       = 0;
    row_pos         = 0;
    col_pos         = 0;
    frame_count     = 0;
    min_size        = MAX_SIZE;
    max_size        = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    modes = '{GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // smallest image: four corners, full-scale and zero channels,
    // a pixel flagged as drain and a drain flagged as pixel
    write_size(CFG_W'(MIN_SIZE));
    push_req(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_req(1'b1, 16'h0000, 16'h0000, 16'h0000);
    push_req(1'b0, 16'hFFFF, 16'h0000, 16'h8001);
    push_req(1'b0, 16'h0000, 16'hFFFF, 16'h7FFE);
    push_req(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_req(1'b0, 16'h1234, 16'hABCD, 16'h5A5A);
    push_req(1'b1, 16'h0000, 16'h0000, 16'h0000);
    frame_count++;
    min_size = MIN_SIZE;
    max_size = MIN_SIZE;
    wait_idle();

    // 3x3: corners, edges and one full window over mostly full-scale pixels
    write_size(CFG_W'(3));
    for (int unsigned p = 0; p < 9; p++) begin
      if (p == 0) begin
        push_req(1'b0, 16'h0000, 16'h0000, 16'h0000);
      end else if (p == 8) begin
        push_req(1'b0, 16'h0001, 16'hFFFE, 16'h0001);
      end else begin
        push_req(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end
    end
    for (int unsigned d = 0; d < 4; d++) begin
      push_req(1'b1, rand_chan(), rand_chan(), rand_chan());
    end
    frame_count++;
    if (max_size < 3) max_size = 3;
    wait_idle();

    // random images under each gap pattern; about half keep the size and
    // run back to back, the rest change it while the core is idle
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk_i);
      gap_mode <= modes[ph];
      phase_reqs = 0;
      while (phase_reqs < PHASE_REQS) begin
        if ($urandom_range(1) == 0 || phase_reqs == 0) begin
          wait_idle();
          write_size(pick_size());
        end
        queue_image(n_reqs);
        phase_reqs += n_reqs;
      end
      wait_idle();
    end

    @(posedge clk_i);
    gap_mode <= GAP_NONE;
    wait_idle();
    repeat (SETTLE) @(posedge clk_i);

    if (mean_q.size() != 0) begin
      fail_note($sformatf("%0d predicted results never came", mean_q.size()));
    end

    $display("covered %0d images, sizes %0d to %0d, %0d requests under four gap patterns",
             frame_count, min_size, max_size, req_count);
    $display("checked %0d filtered pixels, %0d image ends, %0d mismatches",
             mean_count, last_count, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
